/* rtl/b26_pkg.sv */
package b26_pkg;

  // fixed field widths
  localparam int unsigned ValW     = 64;
  localparam int unsigned CharW    = 8;
  localparam int unsigned MinDigW  = 6;

  // base-26 digit row: 26^14 > 2^64, so fourteen digits always suffice
  localparam int unsigned Radix    = 26;
  localparam int unsigned DigW     = 5;
  localparam int unsigned NumDig   = 14;
  localparam int unsigned DigIdxW  = 4;
  localparam int unsigned CntW     = 4;

  // converter shifts this many value bits into the digit row per cycle
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned NumSteps    = ValW / BitsPerStep;
  localparam int unsigned StepCntW    = 4;

  // hand-off queue between converter and emitter
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = 1;
  localparam int unsigned FifoCntW  = 2;

  // character codes and register file
  localparam logic [CharW-1:0] MinusCode  = 8'd45;
  localparam logic [CharW-1:0] AlphaReset = 8'd97;
  localparam int unsigned      CfgAddrW   = 3;
  localparam int unsigned      CfgDataW   = 32;
  localparam logic             RegAlpha   = 1'b0;
  localparam logic             RegMinDig  = 1'b1;

  typedef logic [DigW-1:0] digit_t;

  typedef struct packed {
    digit_t [NumDig-1:0] digits;
    logic [CntW-1:0]     count;
    logic                neg;
  } conv_item_t;

  // one doubling step of a base-26 digit cell: returns {carry out, new digit};
  // the carry out depends on the old digit only, never on the carry in
  function automatic logic [DigW:0] dbl_digit(digit_t d, logic cin);
    logic          carry;
    logic [DigW:0] twice;
    digit_t        res;
    carry = (d >= digit_t'(Radix / 2));
    twice = {d, 1'b0};
    if (carry) begin
      twice = twice - (DigW + 1)'(Radix);
    end
    res = twice[DigW-1:0] + digit_t'(cin);
    return {carry, res};
  endfunction

endpackage

/* rtl/integer_to_base26_chars_core.sv */
// flow: the converter shifts a taken value 4 bits at a time through the 14-digit base-26
//   cell row and takes no new value until it hands that one off (it may take the next one as
//   it hands off); the emitter gives one character per cycle while the receiver pops
// reset: rst_ni asynchronous, active low; queues empty, alphabet_base = 97, min_digits = 0
module integer_to_base26_chars_core import b26_pkg::*; #(
  parameter int unsigned MAX_CHARS = 40
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // value side
  input  logic                push,
  output logic                full,
  input  logic [ValW-1:0]     value_i,
  input  logic                is_signed_i,
  // character side
  input  logic                pop,
  output logic                empty,
  output logic [CharW-1:0]    char_code_o,
  output logic                last_o,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // register file: byte address 4 * index, index in the top address bit
  logic [CharW-1:0]   alpha_q;
  logic [MinDigW-1:0] min_dig_q;
  logic               cfg_wr;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CfgAddrW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q   <= AlphaReset;
      min_dig_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegAlpha:  alpha_q   <= pwdata[CharW-1:0];
        RegMinDig: min_dig_q <= pwdata[MinDigW-1:0];
        default:   alpha_q   <= alpha_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegAlpha:  prdata = CfgDataW'(alpha_q);
      RegMinDig: prdata = CfgDataW'(min_dig_q);
      default:   prdata = '0;
    endcase
  end

  // front: negate, then binary to base-26 digit row
  conv_item_t conv_item, fifo_item;
  logic       fifo_push, fifo_full, fifo_pop, fifo_empty;

  b26_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .value_i     (value_i),
    .is_signed_i (is_signed_i),
    .full_o      (full),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .item_o      (conv_item)
  );

  // two converted items can wait while a long run drains
  b26_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (conv_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (fifo_item)
  );

  // back: sign, padding and digits out of a registered output stage
  b26_emit #(
    .MAX_CHARS (MAX_CHARS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .item_i       (fifo_item),
    .fifo_pop_o   (fifo_pop),
    .alpha_i      (alpha_q),
    .min_digits_i (min_dig_q),
    .pop_i        (pop),
    .empty_o      (empty),
    .char_code_o  (char_code_o),
    .last_o       (last_o)
  );

`ifndef NO_ASSERTIONS
  // a run never breaks up: after a character that is not the last, the next one is ready
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !last_o |=> !empty)
    else $error("gap inside a character run");

  // a taken value keeps the converter busy in the next cycle
  a_conv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full)
    else $error("converter free right after taking a value");

  // an item drawn from the queue is loaded into the run registers, then a character shows at the output register
  a_load_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> ##2 !empty)
    else $error("loaded item produced no character");
`endif

endmodule

/* rtl/b26_fifo.sv */
module b26_fifo import b26_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  conv_item_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output conv_item_t data_o
);

  conv_item_t [FifoDepth-1:0] mem_q;
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + FifoCntW'(do_push) - FifoCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/b26_conv.sv */
module b26_conv import b26_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ValW-1:0]  value_i,
  input  logic             is_signed_i,
  output logic             full_o,
  input  logic             fifo_full_i,
  output logic             fifo_push_o,
  output conv_item_t       item_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [ValW-1:0]     mag_q, mag_d;
  digit_t [NumDig-1:0] digits_q, digits_d, digits_step;
  logic                neg_q, neg_d;
  logic [StepCntW-1:0] step_q, step_d;
  logic                accept, in_neg;
  logic [CntW-1:0]     count;

  assign fifo_push_o = (state_q == StDone) && !fifo_full_i;
  assign full_o      = !((state_q == StIdle) || fifo_push_o);
  assign accept      = push_i && !full_o;
  assign in_neg      = is_signed_i && value_i[ValW-1];

  // shift the top value bits into the digit row, msb first
  always_comb begin
    logic [DigW:0] dbl_res;
    logic          c;
    digits_step = digits_q;
    for (int s = 0; s < BitsPerStep; s++) begin
      c = mag_q[ValW-1-s];
      for (int i = 0; i < NumDig; i++) begin
        dbl_res        = dbl_digit(digits_step[i], c);
        c              = dbl_res[DigW];
        digits_step[i] = dbl_res[DigW-1:0];
      end
    end
  end

  // significant digit count, at least one
  always_comb begin
    count = CntW'(1);
    for (int i = 1; i < NumDig; i++) begin
      if (digits_q[i] != '0) begin
        count = CntW'(i + 1);
      end
    end
  end

  assign item_o.digits = digits_q;
  assign item_o.count  = count;
  assign item_o.neg    = neg_q;

  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    digits_d = digits_q;
    neg_d    = neg_q;
    step_d   = step_q;
    if (accept) begin
      mag_d    = in_neg ? ValW'(0) - value_i : value_i;
      neg_d    = in_neg;
      digits_d = '0;
      step_d   = '0;
    end
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StConv;
        end
      end
      StConv: begin
        mag_d    = mag_q << BitsPerStep;
        digits_d = digits_step;
        step_d   = step_q + 1'b1;
        if (step_q == StepCntW'(NumSteps - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (fifo_push_o) begin
          state_d = accept ? StConv : StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    digits_q <= digits_d;
  end

endmodule

/* rtl/b26_emit.sv */
module b26_emit import b26_pkg::*; #(
  parameter int unsigned MAX_CHARS = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fifo_empty_i,
  input  conv_item_t         item_i,
  output logic               fifo_pop_o,
  input  logic [CharW-1:0]   alpha_i,
  input  logic [MinDigW-1:0] min_digits_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [CharW-1:0]   char_code_o,
  output logic               last_o
);

  localparam int unsigned RemW = $clog2(MAX_CHARS);
  localparam int unsigned TotW = (RemW > MinDigW) ? RemW : MinDigW;
  localparam logic [TotW-1:0] CapDigits = TotW'(MAX_CHARS - 1);

  logic                out_valid_q, out_valid_d;
  logic [CharW-1:0]    char_q, char_d;
  logic                last_q, last_d;
  logic                sign_q, sign_d;
  logic [RemW-1:0]     rem_q, rem_d;
  digit_t [NumDig-1:0] digits_q, digits_d;
  logic [CntW-1:0]     count_q, count_d;

  logic                busy, adv, emit, in_digits;
  logic [RemW-1:0]     idx;
  logic [TotW-1:0]     tot;
  digit_t              dsel;

  assign busy       = sign_q || (rem_q != '0);
  assign adv        = !out_valid_q || pop_i;
  assign emit       = adv && busy;
  assign fifo_pop_o = !busy && !fifo_empty_i;
  assign idx        = rem_q - 1'b1;
  assign in_digits  = (idx < RemW'(count_q));
  assign dsel       = digits_q[idx[DigIdxW-1:0]];

  // digit characters of the next run: padded up, capped so the sign still fits
  always_comb begin
    tot = TotW'(item_i.count);
    if (TotW'(min_digits_i) > tot) begin
      tot = TotW'(min_digits_i);
    end
    if (tot > CapDigits) begin
      tot = CapDigits;
    end
  end

  always_comb begin
    out_valid_d = adv ? busy : out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    sign_d      = sign_q;
    rem_d       = rem_q;
    digits_d    = digits_q;
    count_d     = count_q;
    if (emit) begin
      if (sign_q) begin
        char_d = MinusCode;
        last_d = 1'b0;
        sign_d = 1'b0;
      end else begin
        char_d = in_digits ? alpha_i + CharW'(dsel) : alpha_i;
        last_d = (rem_q == RemW'(1));
        rem_d  = idx;
      end
    end
    if (fifo_pop_o) begin
      digits_d = item_i.digits;
      count_d  = item_i.count;
      sign_d   = item_i.neg;
      rem_d    = RemW'(tot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sign_q      <= 1'b0;
      rem_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      sign_q      <= sign_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    last_q   <= last_d;
    digits_q <= digits_d;
    count_q  <= count_d;
  end

  assign empty_o     = !out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import b26_pkg::*;

  // run-length cap of the instance under test
  localparam int unsigned MaxChars = 40;

  // register addresses on the apb port, one 32-bit word per register
  localparam logic [CfgAddrW-1:0] AlphaAddr  = CfgAddrW'({RegAlpha, 2'b00});
  localparam logic [CfgAddrW-1:0] MinDigAddr = CfgAddrW'({RegMinDig, 2'b00});

  // cycles with no accepted item or register access before the run is called hung
  localparam int unsigned WatchdogLimit = 3000;
  // long receiver hold-off used to fill the block and stall its input
  localparam int unsigned LongHold      = 300;
  // quiet cycles after the last character, well past the first-char latency
  localparam int unsigned TailCycles    = 40;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } b26_char_t;

  // expected character store plus the radix-26 renderer that fills it
  class b26_char_board;
    logic [CharW-1:0]   alpha_base;
    logic [MinDigW-1:0] min_digits;
    b26_char_t          expected_chars[$];
    int unsigned        mismatches;

    function new();
      alpha_base = AlphaReset;
      min_digits = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    // render one accepted value into the characters it must produce
    function void note_value(logic [ValW-1:0] v, logic s);
      logic            neg;
      logic [ValW-1:0] mag;
      digit_t          digs [NumDig];
      int unsigned     n, width, pad, total, pos;
      b26_char_t       c;
      neg = s & v[ValW-1];
      mag = neg ? -v : v;
      n = 0;
      // zero still gives one digit
      do begin
        digs[n] = digit_t'(mag % ValW'(Radix));
        mag = mag / ValW'(Radix);
        n++;
      end while (mag != 0);
      width = (min_digits > n) ? min_digits : n;
      if (width > MaxChars - 1) width = MaxChars - 1;
      pad = width - n;
      total = width + (neg ? 1 : 0);
      pos = 0;
      if (neg) begin
        c.code = MinusCode;
        c.last = (pos + 1 == total);
        expected_chars.push_back(c);
        pos++;
      end
      repeat (pad) begin
        c.code = alpha_base;
        c.last = (pos + 1 == total);
        expected_chars.push_back(c);
        pos++;
      end
      for (int i = n - 1; i >= 0; i--) begin
        c.code = alpha_base + CharW'(digs[i]);
        c.last = (pos + 1 == total);
        expected_chars.push_back(c);
        pos++;
      end
    endfunction

    // compare one accepted character against the oldest expectation
    function void check_char(logic [CharW-1:0] code, logic last);
      b26_char_t e;
      if (expected_chars.size() == 0) begin
        $display("%0t: char with nothing expected: code %0d last %0b", $time, code, last);
        mismatches++;
        return;
      end
      e = expected_chars.pop_front();
      if (code !== e.code) begin
        $display("%0t: char_code mismatch: expected %0d actual %0d", $time, e.code, code);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: last mismatch: expected %0b actual %0b", $time, e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic [ValW-1:0]     value_i     = '0;
  logic                is_signed_i = 1'b0;
  logic                pop         = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic                full;
  logic                empty;
  logic [CharW-1:0]    char_code_o;
  logic                last_o;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  b26_char_board board = new();
  int unsigned   cfg_errors    = 0;
  int unsigned   idle_cycles   = 0;
  // idling controls shared by the sender, the receiver and the sequence
  bit            tx_steady     = 1'b0;
  bit            rx_steady     = 1'b0;
  bit            tx_burst      = 1'b0;
  int unsigned   rx_stall_req  = 0;
  int unsigned   rx_wait       = 0;

  integer_to_base26_chars_core #(
    .MAX_CHARS(MaxChars)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .is_signed_i(is_signed_i),
    .pop        (pop),
    .empty      (empty),
    .char_code_o(char_code_o),
    .last_o     (last_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // idle lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ValW-1:0] pow26(int unsigned k);
    logic [ValW-1:0] p;
    p = ValW'(1);
    repeat (k) p = p * ValW'(Radix);
    return p;
  endfunction

  // random value mix: full-width noise, small values, digit-count
  // boundaries, negatives and the corner values of both readings
  function automatic void pick_value(output logic [ValW-1:0] v, output logic s);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    s = 1'($urandom_range(0, 1));
    case (kind)
      0, 1, 2: v = {$urandom, $urandom};
      3, 4: v = ValW'($urandom_range(0, 20000));
      5: v = pow26($urandom_range(1, 13)) + ValW'($urandom_range(0, 2)) - 1;
      6: begin
        v = -ValW'($urandom_range(1, 100000));
        s = 1'b1;
      end
      7: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      8: v = -pow26($urandom_range(1, 13)) + ValW'($urandom_range(0, 2)) - 1;
      default: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = {1'b1, {(ValW-1){1'b0}}};
          2: v = '1;
          default: v = {1'b0, {(ValW-1){1'b1}}};
        endcase
      end
    endcase
  endfunction

  // offer one value; returns on the edge that takes it
  task automatic push_value(input logic [ValW-1:0] v, input logic s);
    int unsigned gap;
    @(negedge clk_i);
    gap = tx_burst ? 0 : pick_gap(tx_steady);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    value_i     <= v;
    is_signed_i <= s;
    do @(posedge clk_i); while (full !== 1'b0);
  endtask

  // stop offering and wait until every expected character has come out
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic reg_write(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(input logic [CfgAddrW-1:0] addr, output logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one setting of both registers followed by a batch of random values;
  // upper write bits carry noise, the block keeps only the register width
  task automatic run_phase(input logic [CharW-1:0] alpha, input logic [MinDigW-1:0] mind,
                           input int unsigned n, input bit pressure);
    logic [CfgDataW-1:0] data;
    logic [ValW-1:0]     v;
    logic                s;
    drain();
    data = $urandom;
    data[CharW-1:0] = alpha;
    reg_write(AlphaAddr, data);
    data = $urandom;
    data[MinDigW-1:0] = mind;
    reg_write(MinDigAddr, data);
    board.alpha_base = alpha;
    board.min_digits = mind;
    reg_read(AlphaAddr, data);
    if (data[CharW-1:0] !== alpha) begin
      $display("%0t: alphabet_base readback: expected %0d actual %0d", $time, alpha,
               data[CharW-1:0]);
      cfg_errors++;
    end
    reg_read(MinDigAddr, data);
    if (data[MinDigW-1:0] !== mind) begin
      $display("%0t: min_digits readback: expected %0d actual %0d", $time, mind,
               data[MinDigW-1:0]);
      cfg_errors++;
    end
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    // receiver holds off while values keep coming back to back
    if (pressure) begin
      rx_stall_req = LongHold;
      tx_burst = 1'b1;
      repeat (14) begin
        pick_value(v, s);
        push_value(v, s);
      end
      tx_burst = 1'b0;
    end
    repeat (n) begin
      pick_value(v, s);
      push_value(v, s);
    end
  endtask

  // receiver: pop after random gaps, or sit out a requested long hold
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (rx_stall_req != 0) begin
        rx_wait = rx_stall_req;
        rx_stall_req = 0;
      end
      if (rx_wait != 0) begin
        pop <= 1'b0;
        rx_wait--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty && rx_wait == 0) rx_wait = pick_gap(rx_steady);
    end
  end

  // monitor: note accepted values, check accepted characters, and watch
  // for a run that stops making progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) board.note_value(value_i, is_signed_i);
      if (pop && !empty) board.check_char(char_code_o, last_o);
      if ((push && !full) || (pop && !empty) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("integer_to_base26_chars_core verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed values under the reset setting ('a', no padding)
    push_value(64'd0, 1'b0);                      // zero, unsigned
    push_value(64'd0, 1'b1);                      // zero, signed
    push_value(64'd1, 1'b0);
    push_value(64'd25, 1'b0);                     // largest single digit
    push_value(64'd26, 1'b1);                     // first two-digit value
    push_value(64'd675, 1'b0);
    push_value(64'd676, 1'b0);
    push_value(pow26(13) - 1, 1'b0);              // thirteen digits
    push_value(pow26(13), 1'b0);                  // fourteen digits
    push_value('1, 1'b0);                         // all ones, unsigned
    push_value('1, 1'b1);                         // minus one
    push_value({1'b1, {(ValW-1){1'b0}}}, 1'b1);   // most negative signed
    push_value({1'b1, {(ValW-1){1'b0}}}, 1'b0);   // top bit set, unsigned
    push_value({1'b0, {(ValW-1){1'b1}}}, 1'b1);   // most positive signed
    push_value(-64'd26, 1'b1);
    push_value(-pow26(13), 1'b1);

    // register settings, extremes included: padding past the cap,
    // character wrap, alphabet at both ends
    run_phase(8'd65, 6'd0, 40, 1'b0);
    run_phase(8'd0, 6'd39, 40, 1'b1);
    run_phase(8'd255, 6'd63, 25, 1'b0);
    run_phase(8'd250, 6'd14, 45, 1'b0);
    run_phase(CharW'($urandom_range(0, 255)), MinDigW'($urandom_range(0, 20)), 45, 1'b1);
    run_phase(8'd97, 6'd3, 45, 1'b0);

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (board.pending() != 0) begin
      $display("%0t: %0d characters still expected", $time, board.pending());
    end
    if (board.mismatches == 0 && cfg_errors == 0 && board.pending() == 0) begin
      $display("integer_to_base26_chars_core verification clean");
    end else begin
      $display("integer_to_base26_chars_core verification failed");
    end
    $finish;
  end

endmodule
